@@ rtl/core/stable_trimmed_mean_assert.svh @@
// assertion macros shared by the checker of stable_trimmed_mean
// expects signals named clk and rst in the scope where a macro is used
`ifndef STABLE_TRIMMED_MEAN_ASSERT_SVH
`define STABLE_TRIMMED_MEAN_ASSERT_SVH

// antecedent and consequent in the same cycle
`define STM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stable_trimmed_mean: same-cycle check failed");

// consequent in the cycle after the antecedent
`define STM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stable_trimmed_mean: next-cycle check failed");

`endif

@@ rtl/core/stm_pkg.sv @@
// shared constants, types and register codes of the trimmed-mean block
// no dependencies
`timescale 1ns / 1ps

package stm_pkg;

  localparam int MAX_SAMPLES  = 32;
  localparam int SAMPLE_WIDTH = 24;

  localparam int COUNT_WIDTH = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_WIDTH   = SAMPLE_WIDTH + $clog2(MAX_SAMPLES);
  localparam int DIV_WIDTH   = $clog2(MAX_SAMPLES - 1);
  localparam int STEP_WIDTH  = $clog2(SUM_WIDTH);

  localparam int COUNT_CFG_WIDTH  = 6;
  localparam int SPREAD_CFG_WIDTH = 8;
  localparam int FLOOR_CFG_WIDTH  = 24;
  localparam int CFG_DATA_WIDTH   = 24;
  localparam int CFG_INDEX_WIDTH  = 2;

  localparam logic [COUNT_CFG_WIDTH-1:0]  SAMPLE_COUNT_RESET = 6'd10;
  localparam logic [SPREAD_CFG_WIDTH-1:0] SPREAD_LIMIT_RESET = 8'd26;
  localparam logic [FLOOR_CFG_WIDTH-1:0]  LOAD_FLOOR_RESET   = 24'd500;

  localparam logic [COUNT_WIDTH-1:0] MIN_BATCH = COUNT_WIDTH'(3);
  localparam logic [COUNT_WIDTH-1:0] MAX_BATCH = COUNT_WIDTH'(MAX_SAMPLES);
  localparam logic [COUNT_WIDTH-1:0] TRIM_COUNT = COUNT_WIDTH'(2);
  localparam logic [STEP_WIDTH-1:0]  LAST_STEP = STEP_WIDTH'(SUM_WIDTH - 1);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SAMPLE_COUNT = 2'd0,
    REG_SPREAD_LIMIT = 2'd1,
    REG_LOAD_FLOOR   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_JUDGE,
    ST_DIVIDE
  } stm_state_t;

  typedef struct packed {
    logic update;
    logic clear;
  } acc_ctrl_t;

endpackage

@@ rtl/core/stm_accum.sv @@
// running sum, maximum, minimum and sample count of the current batch
// depends on stm_pkg
`timescale 1ns / 1ps

module stm_accum (
  input  logic                                     clk,
  input  logic                                     rst,
  input  stm_pkg::acc_ctrl_t                       ctrl,
  input  logic signed [stm_pkg::SAMPLE_WIDTH-1:0]  sample,
  output logic signed [stm_pkg::SUM_WIDTH-1:0]     sum,
  output logic signed [stm_pkg::SAMPLE_WIDTH-1:0]  max_val,
  output logic signed [stm_pkg::SAMPLE_WIDTH-1:0]  min_val,
  output logic [stm_pkg::COUNT_WIDTH-1:0]          seen
);
  import stm_pkg::*;

  logic first;
  logic take_max;
  logic take_min;

  always_comb begin
    first    = (seen == '0);
    take_max = first || (sample > max_val);
    take_min = first || (sample < min_val);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum     <= '0;
      max_val <= '0;
      min_val <= '0;
      seen    <= '0;
    end else if (ctrl.update) begin
      sum  <= sum + SUM_WIDTH'(sample);
      seen <= seen + COUNT_WIDTH'(1);
      if (take_max) begin
        max_val <= sample;
      end
      if (take_min) begin
        min_val <= sample;
      end
    end
  end

endmodule

@@ rtl/core/stm_divider.sv @@
// restoring divider, one quotient bit per cycle, truncates toward zero
// depends on stm_pkg
`timescale 1ns / 1ps

module stm_divider (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     load,
  input  logic signed [stm_pkg::SUM_WIDTH-1:0]     dividend,
  input  logic [stm_pkg::DIV_WIDTH-1:0]            divisor,
  output logic                                     done,
  output logic signed [stm_pkg::SAMPLE_WIDTH-1:0]  quotient
);
  import stm_pkg::*;

  logic                  active;
  logic [STEP_WIDTH-1:0] step;
  logic                  negative;
  logic [SUM_WIDTH-1:0]  quot;
  logic [DIV_WIDTH-1:0]  rem;
  logic [DIV_WIDTH-1:0]  dsor;

  logic [SUM_WIDTH-1:0]  magnitude;
  logic [DIV_WIDTH:0]    trial;
  logic                  fits;
  logic [DIV_WIDTH-1:0]  rem_next;
  logic [SUM_WIDTH-1:0]  quot_next;
  logic [SUM_WIDTH-1:0]  signed_q;
  logic                  last;

  always_comb begin
    magnitude = dividend[SUM_WIDTH-1] ? (~dividend + SUM_WIDTH'(1)) : dividend;
    trial     = {rem, quot[SUM_WIDTH-1]};
    fits      = (trial >= {1'b0, dsor});
    rem_next  = fits ? DIV_WIDTH'(trial - {1'b0, dsor}) : DIV_WIDTH'(trial);
    quot_next = {quot[SUM_WIDTH-2:0], fits};
    signed_q  = negative ? (~quot_next + SUM_WIDTH'(1)) : quot_next;
    last      = active && (step == LAST_STEP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= last;
      if (load) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + STEP_WIDTH'(1);
        if (last) begin
          active <= 1'b0;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      negative <= dividend[SUM_WIDTH-1];
      quot     <= magnitude;
      rem      <= '0;
      dsor     <= divisor;
    end else if (active) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
    if (last) begin
      quotient <= signed_q[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

@@ rtl/core/stable_trimmed_mean.sv @@
// top level of the load-cell trimmed-mean averager with stability check
// depends on stm_pkg, stm_accum and stm_divider
`timescale 1ns / 1ps

// usage
//   input: drive weight_sample and raise start; the beat is taken on a rising
//   edge where start is high and busy is low. busy stays high while a sample
//   is worked on.
//   config: cfg_write with cfg_index and cfg_data writes one register at the
//   edge (0 sample_count, 1 spread_limit_q8, 2 load_floor); index 3 is ignored.
//   write only while busy is low; writes do not restart the current batch.
//   output: done pulses for one cycle with batch_accepted and weight_average.
//   the receiver cannot stall, so the result must be caught in that cycle.
// timing
//   a sample that does not close its batch passes through accept and accumulate.
//   the closing sample then goes to a judge step that either rejects the batch
//   or starts the single restoring divider, which produces one bit per cycle
//   over the full sum width, and that loop sets the latency of a stable batch.
//   one sample at a time is in flight; no result per non-closing sample.
// reset
//   rst is synchronous; it restores register defaults, empties the batch and
//   returns the sequencer to idle. no clearing pass is needed.
module stable_trimmed_mean (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [stm_pkg::SAMPLE_WIDTH-1:0]  weight_sample,
  input  logic                                     cfg_write,
  input  logic [stm_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
  input  logic [stm_pkg::CFG_DATA_WIDTH-1:0]       cfg_data,
  output logic                                     done,
  output logic                                     batch_accepted,
  output logic signed [stm_pkg::SAMPLE_WIDTH-1:0]  weight_average
);
  import stm_pkg::*;

  // configuration registers
  logic [COUNT_CFG_WIDTH-1:0]  sample_count;
  logic [SPREAD_CFG_WIDTH-1:0] spread_limit_q8;
  logic [FLOOR_CFG_WIDTH-1:0]  load_floor;

  // sequencer
  stm_state_t state;
  stm_state_t state_next;

  // latched input beat
  logic signed [SAMPLE_WIDTH-1:0] sample_reg;

  // batch state from the accumulator
  acc_ctrl_t                      acc_ctrl;
  logic signed [SUM_WIDTH-1:0]    sample_sum;
  logic signed [SAMPLE_WIDTH-1:0] sample_max;
  logic signed [SAMPLE_WIDTH-1:0] sample_min;
  logic [COUNT_WIDTH-1:0]         samples_seen;

  // divider handshake
  logic                           div_load;
  logic                           div_done;
  logic signed [SAMPLE_WIDTH-1:0] div_quotient;
  logic signed [SUM_WIDTH-1:0]    trimmed_sum;
  logic [DIV_WIDTH-1:0]           divisor;

  // batch judgement
  logic [COUNT_WIDTH-1:0]      batch_len;
  logic                        batch_end;
  logic signed [SAMPLE_WIDTH+1:0] min_plus_max;
  logic                        above_floor;
  logic [SAMPLE_WIDTH-1:0]     spread;
  logic [SAMPLE_WIDTH+SPREAD_CFG_WIDTH-1:0] spread_scaled;
  logic [SAMPLE_WIDTH+SPREAD_CFG_WIDTH-1:0] spread_bound;
  logic                        unstable;

  // result emission
  logic                           emit;
  logic                           emit_accept;
  logic signed [SAMPLE_WIDTH-1:0] emit_value;

  assign busy = (state != ST_IDLE);

  // register writes; out-of-list index drops the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= SAMPLE_COUNT_RESET;
      spread_limit_q8 <= SPREAD_LIMIT_RESET;
      load_floor      <= LOAD_FLOOR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT: sample_count    <= cfg_data[COUNT_CFG_WIDTH-1:0];
        REG_SPREAD_LIMIT: spread_limit_q8 <= cfg_data[SPREAD_CFG_WIDTH-1:0];
        REG_LOAD_FLOOR:   load_floor      <= cfg_data[FLOOR_CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // batch length clamped to the supported range
  always_comb begin
    priority if (COUNT_WIDTH'(sample_count) < MIN_BATCH) begin
      batch_len = MIN_BATCH;
    end else if (COUNT_WIDTH'(sample_count) > MAX_BATCH) begin
      batch_len = MAX_BATCH;
    end else begin
      batch_len = COUNT_WIDTH'(sample_count);
    end
  end

  // the batch closes once the count reaches the length, also if the length
  // was lowered under the count mid-batch
  assign batch_end = ((samples_seen + COUNT_WIDTH'(1)) >= batch_len);

  // stability test, evaluated on the registered min and max in the judge state
  always_comb begin
    min_plus_max  = (SAMPLE_WIDTH+2)'(sample_min) + (SAMPLE_WIDTH+2)'(sample_max);
    above_floor   = (min_plus_max > $signed({2'b00, load_floor}));
    spread        = SAMPLE_WIDTH'(sample_max - sample_min);
    spread_scaled = {spread, {SPREAD_CFG_WIDTH{1'b0}}};
    spread_bound  = (SAMPLE_WIDTH+SPREAD_CFG_WIDTH)'(spread_limit_q8)
                  * (SAMPLE_WIDTH+SPREAD_CFG_WIDTH)'($unsigned(sample_min));
    priority if (!above_floor) begin
      unstable = 1'b0;
    end else if (sample_min[SAMPLE_WIDTH-1]) begin
      // negative minimum always passes
      unstable = 1'b0;
    end else if (sample_min == '0) begin
      // zero minimum: any positive maximum is an unbounded spread
      unstable = (sample_max > '0);
    end else begin
      unstable = (spread_scaled > spread_bound);
    end
  end

  // trimmed sum drops exactly one max and one min sample
  always_comb begin
    trimmed_sum = sample_sum - SUM_WIDTH'(sample_max) - SUM_WIDTH'(sample_min);
    divisor     = DIV_WIDTH'(batch_len - TRIM_COUNT);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_next = batch_end ? ST_JUDGE : ST_IDLE;
      end
      ST_JUDGE: begin
        state_next = unstable ? ST_IDLE : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    acc_ctrl    = '0;
    div_load    = 1'b0;
    emit        = 1'b0;
    emit_accept = 1'b0;
    emit_value  = '0;
    unique case (state)
      ST_IDLE: ;
      ST_ACCUM: begin
        acc_ctrl.update = 1'b1;
      end
      ST_JUDGE: begin
        if (unstable) begin
          emit           = 1'b1;
          acc_ctrl.clear = 1'b1;
        end else begin
          div_load = 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          emit           = 1'b1;
          emit_accept    = 1'b1;
          emit_value     = div_quotient;
          acc_ctrl.clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      sample_reg <= weight_sample;
    end
    if (emit) begin
      batch_accepted <= emit_accept;
      weight_average <= emit_value;
    end
  end

  stm_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (acc_ctrl),
    .sample  (sample_reg),
    .sum     (sample_sum),
    .max_val (sample_max),
    .min_val (sample_min),
    .seen    (samples_seen)
  );

  stm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (trimmed_sum),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

@@ rtl/core/stm_checker.sv @@
// port-level checks on stable_trimmed_mean, attached by bind
// depends on stm_pkg and stable_trimmed_mean_assert.svh
`timescale 1ns / 1ps
`include "stable_trimmed_mean_assert.svh"

module stm_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     start,
  input logic                                     busy,
  input logic                                     done,
  input logic                                     batch_accepted,
  input logic signed [stm_pkg::SAMPLE_WIDTH-1:0]  weight_average
);
  import stm_pkg::*;

  // result beat lasts one cycle
  `STM_ASSERT_NEXT(a_done_pulse, done, !done)
  // a rejected batch reports a zero average
  `STM_ASSERT_SAME(a_reject_zero, done && !batch_accepted, weight_average == '0)
  // an accepted input beat makes the block busy
  `STM_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  // a result only appears once the sequencer has returned to idle
  `STM_ASSERT_SAME(a_done_idle, done, !busy)

endmodule

bind stable_trimmed_mean stm_checker u_stm_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .batch_accepted (batch_accepted),
  .weight_average (weight_average)
);

@@ tb/tb_top.sv @@
// testbench for stable_trimmed_mean: directed and random load-cell batches under
// several register settings, each result checked against a batch judge in the bench
// depends on stm_pkg and the stable_trimmed_mean rtl
`timescale 1ns / 1ps

module tb_top;
  import stm_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 5;
  // a closing beat of a stable batch runs the divider over the full sum width,
  // so this covers the longest stretch the block can still be at work
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_BEATS    = 290;
  localparam int LONG_PHASE_BEATS = 100;
  localparam int MAX_REPORTS    = 10;

  // index past the register list, writes to it must be ignored
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [SAMPLE_WIDTH-1:0] WEIGHT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] WEIGHT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef struct {
    logic                           accepted;
    logic signed [SAMPLE_WIDTH-1:0] average;
  } batch_verdict_t;

  // shapes of random batches
  typedef enum int {
    NEAR_LIMIT,   // positive samples whose spread straddles the limit
    ZERO_MIN,     // like near limit, with one sample at zero
    ALL_EQUAL,    // one value repeated
    NEAR_FLOOR,   // min plus max close to the load floor
    WIDE_RANDOM   // any 24-bit pattern
  } batch_kind_t;

  // keeps its own copy of the registers and the running batch, judges each
  // closed batch and holds the verdicts still to come from the block
  class batch_judge;
    logic [COUNT_CFG_WIDTH-1:0]  count_cfg;
    logic [SPREAD_CFG_WIDTH-1:0] spread_cfg;
    logic [FLOOR_CFG_WIDTH-1:0]  floor_cfg;
    longint run_sum;
    longint run_max;
    longint run_min;
    int     seen;
    batch_verdict_t expected_verdicts[$];
    int mismatches;
    int averaged;
    int rejected;
    int samples;

    function new();
      count_cfg  = SAMPLE_COUNT_RESET;
      spread_cfg = SPREAD_LIMIT_RESET;
      floor_cfg  = LOAD_FLOOR_RESET;
      run_sum = 0;
      run_max = 0;
      run_min = 0;
      seen = 0;
      mismatches = 0;
      averaged = 0;
      rejected = 0;
      samples = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                            logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_SAMPLE_COUNT: count_cfg  = data[COUNT_CFG_WIDTH-1:0];
        REG_SPREAD_LIMIT: spread_cfg = data[SPREAD_CFG_WIDTH-1:0];
        REG_LOAD_FLOOR:   floor_cfg  = data[FLOOR_CFG_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // samples per batch after clamping into the supported range
    function int batch_length();
      int n;
      n = int'(count_cfg);
      if (n < int'(MIN_BATCH)) n = int'(MIN_BATCH);
      if (n > int'(MAX_BATCH)) n = int'(MAX_BATCH);
      return n;
    endfunction

    function bit unstable();
      if (run_min + run_max <= longint'(floor_cfg)) return 1'b0;
      if (run_min < 0) return 1'b0;
      // zero minimum: infinite spread unless the maximum is zero too
      if (run_min == 0) return run_max > 0;
      return (run_max - run_min) * 256 > longint'(spread_cfg) * run_min;
    endfunction

    function void take_sample(logic signed [SAMPLE_WIDTH-1:0] weight);
      longint w;
      int n;
      batch_verdict_t v;
      w = longint'(weight);
      n = batch_length();
      samples++;
      if (seen == 0) begin
        run_max = w;
        run_min = w;
      end else begin
        if (w > run_max) run_max = w;
        if (w < run_min) run_min = w;
      end
      run_sum += w;
      seen++;
      // a lowered count closes the batch on the next beat
      if (seen < n) return;
      if (unstable()) begin
        v.accepted = 1'b0;
        v.average  = '0;
      end else begin
        // one max and one min dropped even when samples are equal
        v.accepted = 1'b1;
        v.average  = SAMPLE_WIDTH'((run_sum - run_max - run_min) / longint'(n - 2));
      end
      expected_verdicts.push_back(v);
      run_sum = 0;
      run_max = 0;
      run_min = 0;
      seen = 0;
    endfunction

    function void check_verdict(logic acc, logic signed [SAMPLE_WIDTH-1:0] avg);
      batch_verdict_t v;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none expected: accepted %0b average %0d",
                   $realtime, acc, avg);
        return;
      end
      v = expected_verdicts.pop_front();
      if (v.accepted) averaged++;
      else rejected++;
      if (acc !== v.accepted || avg !== v.average) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch: expected accepted %0b average %0d, %s %0b average %0d",
                   $realtime, v.accepted, v.average, "got accepted", acc, avg);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [SAMPLE_WIDTH-1:0] weight_sample = '0;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic done;
  logic batch_accepted;
  logic signed [SAMPLE_WIDTH-1:0] weight_average;

  batch_judge judge = new();

  int sender_idle_pct = 0;
  int beats_sent = 0;
  int config_sets = 0;
  int quiet_cycles = 0;

  stable_trimmed_mean dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .weight_sample  (weight_sample),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .batch_accepted (batch_accepted),
    .weight_average (weight_average)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // monitor: everything sampled at the edge sees pre-edge values, since both
  // the bench and the block update through nonblocking assignments
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      // a result always belongs to an earlier beat, so check before predicting
      if (done) judge.check_verdict(batch_accepted, weight_average);
      if (cfg_write) judge.write_reg(cfg_index, cfg_data);
      if (start && !busy) judge.take_sample(weight_sample);
      if (done || cfg_write || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // gap after a beat, drawn against the idle share of the current phase
  function automatic int pick_gap();
    if ($urandom_range(99, 0) >= sender_idle_pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(SETTLE_CYCLES, 5);
    return $urandom_range(4, 1);
  endfunction

  function automatic batch_kind_t pick_kind();
    int r;
    r = $urandom_range(9, 0);
    if (r < 5) return NEAR_LIMIT;
    if (r == 5) return ZERO_MIN;
    if (r == 6) return WIDE_RANDOM;
    if (r == 7) return ALL_EQUAL;
    return NEAR_FLOOR;
  endfunction

  // raise start with the beat and hold it until the block takes it; start is
  // left high when no gap is drawn, so a following beat can go out back to back
  task automatic send_beat(input logic signed [SAMPLE_WIDTH-1:0] value);
    int gap;
    start <= 1'b1;
    weight_sample <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one write per edge, with random bits above each register's width
  task automatic configure(input logic [COUNT_CFG_WIDTH-1:0]  count,
                           input logic [SPREAD_CFG_WIDTH-1:0] spread,
                           input logic [FLOOR_CFG_WIDTH-1:0]  floor_val);
    logic [CFG_DATA_WIDTH-1:0] junk;
    junk = CFG_DATA_WIDTH'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= junk;
    @(posedge clk);
    junk = CFG_DATA_WIDTH'($urandom);
    cfg_index <= REG_SAMPLE_COUNT;
    cfg_data  <= {junk[CFG_DATA_WIDTH-1:COUNT_CFG_WIDTH], count};
    @(posedge clk);
    junk = CFG_DATA_WIDTH'($urandom);
    cfg_index <= REG_SPREAD_LIMIT;
    cfg_data  <= {junk[CFG_DATA_WIDTH-1:SPREAD_CFG_WIDTH], spread};
    @(posedge clk);
    cfg_index <= REG_LOAD_FLOOR;
    cfg_data  <= floor_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    config_sets++;
    // one more edge so the judge holds the new settings before they are read
    @(posedge clk);
  endtask

  // wait out every pending verdict, then the tail of a non-closing beat;
  // the caller has already dropped start
  task automatic drain();
    @(posedge clk);
    while (judge.expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // count beats of one shape, scaled from the current registers
  task automatic run_batch(input batch_kind_t kind, input int count);
    longint center;
    longint spread_span;
    longint half_floor;
    longint w;
    logic signed [SAMPLE_WIDTH-1:0] raw;
    logic signed [SAMPLE_WIDTH-1:0] level;
    int zero_at;
    if (count <= 0) return;
    if ($urandom_range(3, 0) == 0) center = longint'($urandom_range(3000, 1));
    else center = longint'($urandom_range(4000000, 1));
    // up to about twice the allowed spread, so both verdicts come up
    spread_span = center * longint'($urandom_range(2 * judge.spread_cfg + 8, 0)) / 256;
    half_floor = longint'(judge.floor_cfg) / 2;
    level = SAMPLE_WIDTH'($urandom);
    case ($urandom_range(3, 0))
      0: level = '0;
      1: level = WEIGHT_MAX;
      2: level = WEIGHT_MIN;
      default: ;
    endcase
    zero_at = $urandom_range(count - 1, 0);
    for (int i = 0; i < count; i++) begin
      raw = SAMPLE_WIDTH'($urandom);
      case (kind)
        NEAR_LIMIT: w = center + longint'($urandom_range(int'(spread_span), 0));
        ZERO_MIN:   w = (i == zero_at) ? 0
                                       : center + longint'($urandom_range(int'(spread_span), 0));
        ALL_EQUAL:  w = longint'(level);
        NEAR_FLOOR: w = half_floor - 40 + longint'($urandom_range(80, 0));
        default:    w = longint'(raw);
      endcase
      // now and then an extreme reading lands inside any shape
      if ($urandom_range(15, 0) == 0) w = raw[0] ? longint'(WEIGHT_MAX) : longint'(WEIGHT_MIN);
      if (w > longint'(WEIGHT_MAX)) w = longint'(WEIGHT_MAX);
      send_beat(SAMPLE_WIDTH'(w));
    end
  endtask

  initial begin
    int edge_beats[15];
    int trunc_beats[5];
    logic [COUNT_CFG_WIDTH-1:0]  cnt;
    logic [SPREAD_CFG_WIDTH-1:0] spr;
    logic [FLOOR_CFG_WIDTH-1:0]  flr;
    int budget;
    int phase_start;
    int pressure_at;
    bit pressure_done;

    // batches of three: all at the top, all at the bottom, zero min with a
    // load, spread over the limit, negative min with a wide spread
    edge_beats = '{int'(WEIGHT_MAX), int'(WEIGHT_MAX), int'(WEIGHT_MAX),
                   int'(WEIGHT_MIN), int'(WEIGHT_MIN), int'(WEIGHT_MIN),
                   0, 1000, 1000,
                   1000, 2000, 1500,
                   -5, 10000, 20000};
    // negative trimmed sum that must truncate toward zero
    trunc_beats = '{-1, -2, -2, -100, 100};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part, no idling
    configure(3, 26, 500);
    for (int i = 0; i < 15; i++) send_beat(SAMPLE_WIDTH'(edge_beats[i]));
    start <= 1'b0;
    drain();
    configure(5, 255, 0);
    for (int i = 0; i < 5; i++) send_beat(SAMPLE_WIDTH'(trunc_beats[i]));
    start <= 1'b0;
    drain();
    // open a long batch, then lower the count below what is already in
    configure(32, 26, 500);
    send_beat(2000);
    send_beat(2100);
    send_beat(2050);
    start <= 1'b0;
    drain();
    configure(0, 26, 500);
    send_beat(2020);
    start <= 1'b0;
    drain();

    // random phases, each under its own settings and idle share
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin cnt = 4;  spr = 26;  flr = 500; end
        1: begin cnt = 63; spr = 0;   flr = 0; end
        2: begin cnt = 3;  spr = 255; flr = 0; end
        3: begin
          cnt = 0;
          spr = SPREAD_CFG_WIDTH'($urandom_range(255, 0));
          flr = FLOOR_CFG_WIDTH'($urandom_range(3000, 0));
        end
        4: begin cnt = 8;  spr = 128; flr = '1; end
        5: begin cnt = 33; spr = 255; flr = FLOOR_CFG_WIDTH'($urandom); end
        6: begin cnt = 5;  spr = 0;   flr = 1000; end
        default: begin
          cnt = COUNT_CFG_WIDTH'($urandom_range(12, 3));
          spr = SPREAD_CFG_WIDTH'($urandom);
          flr = FLOOR_CFG_WIDTH'($urandom_range(2000, 0));
        end
      endcase
      configure(cnt, spr, flr);
      case (p % 4)
        1: sender_idle_pct = 68;
        3: sender_idle_pct = 23;
        default: sender_idle_pct = 0;
      endcase
      // the long batches get fewer beats
      budget = (judge.batch_length() >= 16) ? LONG_PHASE_BEATS : PHASE_BEATS;
      pressure_at = $urandom_range(budget / 2, 0);
      pressure_done = 1'b0;
      phase_start = beats_sent;
      while (beats_sent - phase_start < budget) begin
        run_batch(pick_kind(), judge.batch_length());
        // hold off once until the block has nothing left to report
        if (!pressure_done && beats_sent - phase_start >= pressure_at) begin
          pressure_done = 1'b1;
          start <= 1'b0;
          @(posedge clk);
          while (judge.expected_verdicts.size() != 0) @(posedge clk);
        end
      end
      // leave a partial batch so the next settings take over mid-batch
      run_batch(pick_kind(), $urandom_range(judge.batch_length() - 1, 0));
      start <= 1'b0;
      drain();
    end

    $display("covered %0d beats over %0d register settings", beats_sent, config_sets);
    $display("batches averaged %0d, rejected %0d, mismatches %0d",
             judge.averaged, judge.rejected, judge.mismatches);
    if (judge.mismatches == 0 && judge.expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      if (judge.expected_verdicts.size() != 0)
        $display("%0d expected results never arrived", judge.expected_verdicts.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
